[sv/irpde_pkg.sv]
// Shared types and timing constants for the infrared pulse-distance encoder.
`default_nettype none

package irpde_pkg;

    localparam int DUR_W = 14;
    localparam int SEG_W = 5;

    localparam logic MODE_NEC  = 1'b0;
    localparam logic MODE_AEHA = 1'b1;

    // Segment durations in microseconds for each timing mode.
    localparam logic [DUR_W-1:0] NEC_T1  = 14'd555;
    localparam logic [DUR_W-1:0] NEC_T3  = 14'd1665;
    localparam logic [DUR_W-1:0] NEC_T8  = 14'd4440;
    localparam logic [DUR_W-1:0] NEC_T16 = 14'd8880;
    localparam logic [DUR_W-1:0] AEHA_T1 = 14'd425;
    localparam logic [DUR_W-1:0] AEHA_T3 = 14'd1275;
    localparam logic [DUR_W-1:0] AEHA_T4 = 14'd1700;
    localparam logic [DUR_W-1:0] AEHA_T8 = 14'd3400;

    // Segment numbering within one byte: leader, sixteen bit segments, stop mark.
    localparam logic [SEG_W-1:0] SEG_LEAD_MARK  = 5'd0;
    localparam logic [SEG_W-1:0] SEG_LEAD_SPACE = 5'd1;
    localparam logic [SEG_W-1:0] SEG_FIRST_BIT  = 5'd2;
    localparam logic [SEG_W-1:0] SEG_LAST_BIT   = 5'd17;
    localparam logic [SEG_W-1:0] SEG_STOP       = 5'd18;

    typedef struct packed {
        logic       mode;
        logic       leader;
        logic [7:0] data;
        logic       last;
    } job_t;

endpackage

`default_nettype wire

[sv/ir_remote_pulse_distance_encoder_unit.sv]
// Top level of the infrared pulse-distance encoder with its register port.
//
// Input channel: one frame byte per transfer (data_byte, last_byte), taken
// when in_valid is high and in_stall is low. Output channel: one mark or
// space segment per transfer (carrier_on, duration_us, last_segment), taken
// when out_valid is high and out_stall is low.
// A byte yields 16 bit segments, plus a leader mark and space when it opens
// a frame, plus a stop mark when last_byte is set: 16 to 19 segments.
// The sequencer emits one segment per cycle unless out_stall holds it. With
// the sequencer idle, an input transfer is registered in the queue count and
// then in the out_valid register before out_valid rises.
// A job queue of QUEUE_DEPTH bytes lets new bytes be taken while earlier
// ones are still being sent; in_stall rises only when that queue is full.
// While out_valid and out_stall are both high the current segment holds and the sequencer waits.
// Reset selects NEC timing, empties the queue and starts outside a frame.
// The protocol_mode register at byte address 0 selects NEC (0) or AEHA (1)
// timing and is read again for each byte.
`default_nettype none

module ir_remote_pulse_distance_encoder_unit
    import irpde_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [7:0]       data_byte,
    input  wire logic             last_byte,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic                  carrier_on,
    output logic [DUR_W-1:0]      duration_us,
    output logic                  last_segment
);

    logic mode_reg;
    logic mode_next;
    logic cfg_write;
    logic queue_full;
    logic push;
    logic pop;
    logic head_valid;
    job_t push_job;
    job_t head_job;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign mode_next = cfg_write ? pwdata[0] : mode_reg;
    assign prdata    = (paddr[2] == 1'b0) ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NEC;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    irpde_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    irpde_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    irpde_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_job     (head_job),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .carrier_on   (carrier_on),
        .duration_us  (duration_us),
        .last_segment (last_segment)
    );

endmodule

`default_nettype wire

[sv/irpde_front.sv]
// Front end: accepts bytes, tracks frame position and builds segment jobs.
`default_nettype none

module irpde_front
    import irpde_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       mode,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire logic       queue_full,
    output logic            push,
    output job_t            push_job
);

    logic in_frame_reg;
    logic in_frame_next;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        push_job.mode   = mode;
        push_job.leader = !in_frame_reg;
        push_job.data   = data_byte;
        push_job.last   = last_byte;
        in_frame_next   = in_frame_reg;
        if (push)
        begin
            in_frame_next = !last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

`default_nettype wire

[sv/irpde_queue.sv]
// Short job queue between the front end and the segment sequencer.
`default_nettype none

module irpde_queue
    import irpde_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output job_t      head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_FULL)
        else $error("Queue count exceeds its depth.");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("Queue popped while empty.");
    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("Queue pushed while full.");

endmodule

`default_nettype wire

[sv/irpde_back.sv]
// Back end: steps through the segments of the head job, one per cycle while the output is not stalled.
`default_nettype none

module irpde_back
    import irpde_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  wire job_t              head_job,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   carrier_on,
    output logic [DUR_W-1:0]       duration_us,
    output logic                   last_segment
);

    logic             started_reg;
    logic             started_next;
    logic [SEG_W-1:0] seg_reg;
    logic [SEG_W-1:0] seg_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             carrier_on_reg;
    logic [DUR_W-1:0] duration_reg;
    logic             last_segment_reg;

    logic [SEG_W-1:0] cur_seg;
    logic [SEG_W-1:0] end_seg;
    logic [2:0]       bit_idx;
    logic [3:0]       bit_pos;
    logic             emit;
    logic [DUR_W-1:0] unit_t1;
    logic [DUR_W-1:0] unit_t3;
    logic [DUR_W-1:0] lead_mark;
    logic [DUR_W-1:0] lead_space;
    logic [DUR_W-1:0] seg_dur;

    assign cur_seg = started_reg ? seg_reg
                   : (head_job.leader ? SEG_LEAD_MARK : SEG_FIRST_BIT);
    assign end_seg = head_job.last ? SEG_STOP : SEG_LAST_BIT;
    assign emit    = head_valid && (!out_valid_reg || !out_stall);
    assign pop     = emit && (cur_seg == end_seg);
    assign bit_pos = cur_seg[4:1] - 4'd1;
    assign bit_idx = bit_pos[2:0];

    always_comb
    begin
        if (head_job.mode == MODE_AEHA)
        begin
            unit_t1    = AEHA_T1;
            unit_t3    = AEHA_T3;
            lead_mark  = AEHA_T8;
            lead_space = AEHA_T4;
        end
        else
        begin
            unit_t1    = NEC_T1;
            unit_t3    = NEC_T3;
            lead_mark  = NEC_T16;
            lead_space = NEC_T8;
        end

        case (cur_seg)
            SEG_LEAD_MARK:  seg_dur = lead_mark;
            SEG_LEAD_SPACE: seg_dur = lead_space;
            SEG_STOP:       seg_dur = unit_t1;
            default:
            begin
                if (cur_seg[0] && head_job.data[bit_idx])
                begin
                    seg_dur = unit_t3;
                end
                else
                begin
                    seg_dur = unit_t1;
                end
            end
        endcase
    end

    always_comb
    begin
        started_next   = started_reg;
        seg_next       = seg_reg;
        out_valid_next = out_valid_reg;
        if (!out_valid_reg || !out_stall)
        begin
            out_valid_next = head_valid;
        end
        if (emit)
        begin
            if (pop)
            begin
                started_next = 1'b0;
            end
            else
            begin
                started_next = 1'b1;
                seg_next     = cur_seg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            seg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            started_reg   <= started_next;
            seg_reg       <= seg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Marks are the even-numbered segments, spaces the odd ones.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            carrier_on_reg   <= !cur_seg[0];
            duration_reg     <= seg_dur;
            last_segment_reg <= pop;
        end
    end

    assign out_valid    = out_valid_reg;
    assign carrier_on   = carrier_on_reg;
    assign duration_us  = duration_reg;
    assign last_segment = last_segment_reg;

    assert property (@(posedge clk) disable iff (!rst_n) started_reg |-> head_valid)
        else $error("Job left the queue in the middle of its segments.");
    assert property (@(posedge clk) disable iff (!rst_n) head_valid |-> cur_seg <= end_seg)
        else $error("Segment index ran past the end of the job.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (started_reg && emit && !pop) |=> seg_reg == $past(seg_reg) + 1'b1)
        else $error("Segment index skipped or repeated.");

endmodule

`default_nettype wire
